// ===== src/twmhs_pkg.sv =====
// Shared types and constants for the bounded max-heap top-W selector.
package twmhs_pkg;

   localparam int unsigned CFG_W             = 10;
   localparam int unsigned DIST_W            = 32;
   localparam logic [CFG_W-1:0] DEFAULT_HEAP_SIZE = 10'd300;
   localparam int unsigned QDEPTH            = 2;
   localparam int unsigned QPTR_W            = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W            = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_OFFER = 2'd0,
      KIND_DRAIN = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_OFFER,
      OP_DRAIN,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_FIN,
      ST_DOWN,
      ST_DRAIN
   } state_type;

endpackage

// ===== src/twmhs_front.sv =====
// Front end: accepts request items, drops the no-op ones and queues the rest.
module twmhs_front #(
   parameter int unsigned INDEX_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [twmhs_pkg::DIST_W-1:0]   req_distance,
   input  logic [INDEX_BITS-1:0]          req_cand_index,
   input  logic                           req_valid_req,
   output logic                           cmd_valid,
   input  logic                           cmd_ready,
   output twmhs_pkg::op_type              cmd_op,
   output logic [twmhs_pkg::DIST_W-1:0]   cmd_distance,
   output logic [INDEX_BITS-1:0]          cmd_index
);
   import twmhs_pkg::*;

   op_type                q_op_ff   [QDEPTH];
   logic [DIST_W-1:0]     q_dist_ff [QDEPTH];
   logic [INDEX_BITS-1:0] q_idx_ff  [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;

   logic   accept;
   logic   keep;
   op_type op_class;
   logic   push;
   logic   pop;

   // Classify: invalid offers and the unused kind never reach the back end.
   always_comb begin
      keep     = 1'b0;
      op_class = OP_OFFER;
      unique case (req_kind)
         KIND_OFFER: begin
            keep     = req_valid_req;
            op_class = OP_OFFER;
         end
         KIND_DRAIN: begin
            keep     = 1'b1;
            op_class = OP_DRAIN;
         end
         KIND_CLEAR: begin
            keep     = 1'b1;
            op_class = OP_CLEAR;
         end
         default: begin
            keep     = 1'b0;
            op_class = OP_OFFER;
         end
      endcase
   end

   assign req_stall = (cnt_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;

   assign cmd_op       = q_op_ff[rd_ptr_ff];
   assign cmd_distance = q_dist_ff[rd_ptr_ff];
   assign cmd_index    = q_idx_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_op_ff[wr_ptr_ff]   <= op_class;
         q_dist_ff[wr_ptr_ff] <= req_distance;
         q_idx_ff[wr_ptr_ff]  <= req_cand_index;
      end
   end

endmodule

// ===== src/twmhs_back.sv =====
// Back end: heap memory, sift-up/sift-down sequencer, drain reads and result register.
module twmhs_back #(
   parameter int unsigned MAX_KEPT   = 512,
   parameter int unsigned INDEX_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(MAX_KEPT + 1)-1:0]      w_eff,
   input  logic                                 cmd_valid,
   output logic                                 cmd_ready,
   input  twmhs_pkg::op_type                    cmd_op,
   input  logic [twmhs_pkg::DIST_W-1:0]         cmd_distance,
   input  logic [INDEX_BITS-1:0]                cmd_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [twmhs_pkg::DIST_W-1:0]         rsp_out_distance,
   output logic [INDEX_BITS-1:0]                rsp_out_index,
   output logic                                 rsp_last,
   output logic                                 rsp_empty_res
);
   import twmhs_pkg::*;

   localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int unsigned CW = $clog2(MAX_KEPT + 1);
   localparam int unsigned PW = AW + 2;

   // heap store
   logic [DIST_W-1:0]     heap_dist_mem [MAX_KEPT];
   logic [INDEX_BITS-1:0] heap_idx_mem  [MAX_KEPT];

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DIST_W-1:0]     mem_wdist;
   logic [INDEX_BITS-1:0] mem_widx;
   logic                  mem_re;
   logic [AW-1:0]         mem_ra;
   logic [AW-1:0]         mem_rb;
   logic [DIST_W-1:0]     rd_a_dist_ff;
   logic [INDEX_BITS-1:0] rd_a_idx_ff;
   logic [DIST_W-1:0]     rd_b_dist_ff;
   logic [INDEX_BITS-1:0] rd_b_idx_ff;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         drain_ff, drain_in;
   logic                  out_valid_ff, out_valid_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DIST_W-1:0]     nd_ff, nd_in;
   logic [INDEX_BITS-1:0] ni_ff, ni_in;
   logic [DIST_W-1:0]     root_ff, root_in;
   logic                  last_ff, last_in;
   logic [DIST_W-1:0]     out_dist_ff, out_dist_in;
   logic [INDEX_BITS-1:0] out_idx_ff, out_idx_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_empty_ff, out_empty_in;

   logic                  slot_free;
   logic                  take;
   logic                  can_insert;
   logic                  do_replace;
   logic [AW-1:0]         ins_parent;
   logic [AW-1:0]         parent;
   logic [AW-1:0]         grand;
   logic                  up_move;
   logic [PW-1:0]         left_c;
   logic [PW-1:0]         right_c;
   logic                  left_ok;
   logic                  right_ok;
   logic                  sel_left;
   logic                  sel_right;
   logic [AW-1:0]         child;
   logic [PW-1:0]         child_left;
   logic [AW-1:0]         drain_p;
   logic                  drain_last;

   assign slot_free  = !out_valid_ff || !rsp_stall;
   assign take       = cmd_valid && cmd_ready;
   assign can_insert = (count_ff < w_eff);
   assign do_replace = (count_ff != '0) && (cmd_distance < root_ff);
   assign ins_parent = AW'((PW'(count_ff) - PW'(1)) >> 1);
   assign parent     = AW'((PW'(pos_ff) - PW'(1)) >> 1);
   assign grand      = AW'((PW'(parent) - PW'(1)) >> 1);
   assign up_move    = (rd_a_dist_ff < nd_ff);

   // Sift-down compare: the left child wins a tie, a child must be strictly larger.
   assign left_c    = (PW'(pos_ff) << 1) + PW'(1);
   assign right_c   = left_c + PW'(1);
   assign left_ok   = (left_c < PW'(count_ff));
   assign right_ok  = (right_c < PW'(count_ff));
   always_comb begin
      sel_left  = left_ok && (rd_a_dist_ff > nd_ff);
      sel_right = 1'b0;
      if (right_ok) begin
         if (sel_left) begin
            sel_right = (rd_b_dist_ff > rd_a_dist_ff);
         end else begin
            sel_right = (rd_b_dist_ff > nd_ff);
         end
      end
   end
   assign child      = sel_right ? AW'(right_c) : AW'(left_c);
   assign child_left = (PW'(child) << 1) + PW'(1);

   // Restart a stale drain position before the read.
   assign drain_p    = (PW'(drain_ff) >= PW'(count_ff)) ? '0 : drain_ff;
   assign drain_last = ((PW'(drain_p) + PW'(1)) == PW'(count_ff));

   assign cmd_ready = (state_ff == ST_IDLE) &&
                      ((cmd_op != OP_DRAIN) || (count_ff != '0) || slot_free);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (cmd_op)
                  OP_OFFER: begin
                     if (can_insert) begin
                        state_in = (count_ff == '0) ? ST_IDLE : ST_UP;
                     end else if (do_replace) begin
                        state_in = ST_DOWN;
                     end
                  end
                  OP_DRAIN: begin
                     state_in = (count_ff == '0) ? ST_IDLE : ST_DRAIN;
                  end
                  OP_CLEAR: state_in = ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_UP: begin
            if (up_move) begin
               state_in = (parent == '0) ? ST_FIN : ST_UP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN:   state_in = ST_IDLE;
         ST_DOWN:  state_in = (sel_left || sel_right) ? ST_DOWN : ST_IDLE;
         ST_DRAIN: state_in = slot_free ? ST_IDLE : ST_DRAIN;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdist    = nd_ff;
      mem_widx     = ni_ff;
      mem_re       = 1'b0;
      mem_ra       = '0;
      mem_rb       = '0;
      count_in     = count_ff;
      drain_in     = drain_ff;
      pos_in       = pos_ff;
      nd_in        = nd_ff;
      ni_in        = ni_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_dist_in  = out_dist_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (cmd_op)
                  OP_OFFER: begin
                     nd_in = cmd_distance;
                     ni_in = cmd_index;
                     if (can_insert) begin
                        count_in = count_ff + 1'b1;
                        pos_in   = AW'(count_ff);
                        if (count_ff == '0) begin
                           mem_we    = 1'b1;
                           mem_waddr = '0;
                           mem_wdist = cmd_distance;
                           mem_widx  = cmd_index;
                        end else begin
                           mem_re = 1'b1;
                           mem_ra = ins_parent;
                        end
                     end else if (do_replace) begin
                        pos_in = '0;
                        mem_re = 1'b1;
                        mem_ra = AW'(PW'(1));
                        mem_rb = AW'(PW'(2));
                     end
                  end
                  OP_DRAIN: begin
                     if (count_ff == '0) begin
                        out_valid_in = 1'b1;
                        out_dist_in  = '0;
                        out_idx_in   = '0;
                        out_last_in  = 1'b0;
                        out_empty_in = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = drain_p;
                        last_in  = drain_last;
                        drain_in = drain_last ? '0 : drain_p + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     drain_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_UP: begin
            mem_we = 1'b1;
            if (up_move) begin
               // move the parent down, climb one level
               mem_wdist = rd_a_dist_ff;
               mem_widx  = rd_a_idx_ff;
               pos_in    = parent;
               if (parent != '0) begin
                  mem_re = 1'b1;
                  mem_ra = grand;
               end
            end
         end
         ST_FIN: begin
            mem_we = 1'b1;
         end
         ST_DOWN: begin
            mem_we = 1'b1;
            if (sel_left || sel_right) begin
               // pull the larger child up, descend one level
               mem_wdist = sel_right ? rd_b_dist_ff : rd_a_dist_ff;
               mem_widx  = sel_right ? rd_b_idx_ff : rd_a_idx_ff;
               pos_in    = child;
               mem_re    = 1'b1;
               mem_ra    = AW'(child_left);
               mem_rb    = AW'(child_left + PW'(1));
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_dist_in  = rd_a_dist_ff;
               out_idx_in   = rd_a_idx_ff;
               out_last_in  = last_ff;
               out_empty_in = 1'b0;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // root distance mirror, so a rejected offer costs one compare
   assign root_in = (mem_we && (mem_waddr == '0)) ? mem_wdist : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drain_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      nd_ff        <= nd_in;
      ni_ff        <= ni_in;
      root_ff      <= root_in;
      last_ff      <= last_in;
      out_dist_ff  <= out_dist_in;
      out_idx_ff   <= out_idx_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_dist_mem[mem_waddr] <= mem_wdist;
         heap_idx_mem[mem_waddr]  <= mem_widx;
      end
      if (mem_re) begin
         rd_a_dist_ff <= heap_dist_mem[mem_ra];
         rd_a_idx_ff  <= heap_idx_mem[mem_ra];
         rd_b_dist_ff <= heap_dist_mem[mem_rb];
         rd_b_idx_ff  <= heap_idx_mem[mem_rb];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_distance = out_dist_ff;
   assign rsp_out_index    = out_idx_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_empty_res    = out_empty_ff;

endmodule

// ===== src/top_w_max_heap_select.sv =====
// Bounded max-heap selector that keeps the W nearest candidates offered since the last clear.
//
// Request channel (req_valid / req_stall): kind 0 offers a candidate, kind 1 drains one
// kept entry in heap-array order, kind 2 clears the store; offers with req_valid_req low
// and kind 3 are dropped at the front. Items pass a two-entry queue to the heap engine.
// Result channel (rsp_valid / rsp_stall): one item per drain, rsp_last on the entry at the
// highest held position, rsp_empty_res when nothing is held.
// csr write channel sets W (heap_size, 0 acts as 1, above MAX_KEPT saturates); always ready.
// Engine steps, once it takes an item from the queue:
//   rejected offer, clear, insert into an empty heap: done in ST_IDLE as the item is taken;
//   insert: read the parent, then one memory read and write per level climbed (ST_UP);
//   replacement of the root: one ST_DOWN step per level descended, at most log2(MAX_KEPT);
//   drain: a memory read, then ST_DRAIN loading the result register.
// The heap memory has one write and two registered read ports; that port set sets the
// one-level-per-cycle sift rate. Rejected offers go at one per cycle while the engine is idle.
// Reset empties the heap, rewinds the drain position and sets W to 300; the heap memory
// itself is not cleared. A stalled result holds in the output register while the next
// item already proceeds; the engine waits only when a second drain result is ready.
module top_w_max_heap_select #(
   parameter int unsigned MAX_KEPT   = 512,
   parameter int unsigned INDEX_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic [twmhs_pkg::DIST_W-1:0]       req_distance,
   input  logic [INDEX_BITS-1:0]              req_cand_index,
   input  logic                               req_valid_req,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [twmhs_pkg::DIST_W-1:0]       rsp_out_distance,
   output logic [INDEX_BITS-1:0]              rsp_out_index,
   output logic                               rsp_last,
   output logic                               rsp_empty_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [twmhs_pkg::CFG_W-1:0]        csr_heap_size
);
   import twmhs_pkg::*;

   localparam int unsigned CW = $clog2(MAX_KEPT + 1);

   logic [CFG_W-1:0]      heap_size_ff, heap_size_in;
   logic [CW-1:0]         w_eff;
   logic                  cmd_valid;
   logic                  cmd_ready;
   op_type                cmd_op;
   logic [DIST_W-1:0]     cmd_distance;
   logic [INDEX_BITS-1:0] cmd_index;

   assign csr_ready    = 1'b1;
   assign heap_size_in = (csr_valid && csr_ready) ? csr_heap_size : heap_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_size_ff <= DEFAULT_HEAP_SIZE;
      end else begin
         heap_size_ff <= heap_size_in;
      end
   end

   // clamp W into 1 .. MAX_KEPT
   always_comb begin
      if (heap_size_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(heap_size_ff) > 32'(MAX_KEPT)) begin
         w_eff = CW'(MAX_KEPT);
      end else begin
         w_eff = CW'(heap_size_ff);
      end
   end

   twmhs_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_distance   (req_distance),
      .req_cand_index (req_cand_index),
      .req_valid_req  (req_valid_req),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_op         (cmd_op),
      .cmd_distance   (cmd_distance),
      .cmd_index      (cmd_index)
   );

   twmhs_back #(
      .MAX_KEPT   (MAX_KEPT),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .w_eff            (w_eff),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd_op           (cmd_op),
      .cmd_distance     (cmd_distance),
      .cmd_index        (cmd_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_distance (rsp_out_distance),
      .rsp_out_index    (rsp_out_index),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res)
   );

`ifndef SYNTHESIS
   a_empty_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (!rsp_last && (rsp_out_distance == '0) &&
                                        (rsp_out_index == '0)))
      else $error("empty drain result carries nonzero fields");

   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && !cmd_ready) |=> cmd_valid)
      else $error("queued item lost while the engine was busy");

   a_w_in_range: assert property (@(posedge clock) disable iff (reset)
      (w_eff != '0) && (32'(w_eff) <= 32'(MAX_KEPT)))
      else $error("effective heap size out of range");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the bounded max-heap top-W selector.
module tb;
   import twmhs_pkg::*;

   localparam int unsigned HEAP_DEPTH = 512;
   localparam int unsigned IDX_W = 24;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD = 300;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic [1:0]        kind;
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
      logic              vreq;
   } heap_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
      logic              last;
      logic              empty;
   } drain_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [DIST_W-1:0] req_distance = '0;
   logic [IDX_W-1:0] req_cand_index = '0;
   logic req_valid_req = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DIST_W-1:0] rsp_out_distance;
   logic [IDX_W-1:0] rsp_out_index;
   logic rsp_last;
   logic rsp_empty_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CFG_W-1:0] csr_heap_size = '0;

   // predicted heap state
   logic [DIST_W-1:0] heap_dist [HEAP_DEPTH];
   logic [IDX_W-1:0] heap_idx [HEAP_DEPTH];
   int unsigned kept;
   int unsigned drain_at;
   int unsigned peak_kept;
   logic [CFG_W-1:0] heap_size_reg;

   heap_req_type pending[$];
   drain_item_type drain_results_due[$];
   heap_req_type drive_item;

   int requests_taken = 0;
   int drains_checked = 0;
   int mismatches = 0;
   int settings_used = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_asks = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int idle_cycles = 0;

   top_w_max_heap_select #(
      .MAX_KEPT(HEAP_DEPTH),
      .INDEX_BITS(IDX_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_distance(req_distance),
      .req_cand_index(req_cand_index),
      .req_valid_req(req_valid_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_distance(rsp_out_distance),
      .rsp_out_index(rsp_out_index),
      .rsp_last(rsp_last),
      .rsp_empty_res(rsp_empty_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_heap_size(csr_heap_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void swap_entries(int unsigned a, int unsigned b);
      logic [DIST_W-1:0] td;
      logic [IDX_W-1:0] ti;
      td = heap_dist[a];
      ti = heap_idx[a];
      heap_dist[a] = heap_dist[b];
      heap_idx[a] = heap_idx[b];
      heap_dist[b] = td;
      heap_idx[b] = ti;
   endfunction

   // Append one item to the sender's queue.
   function automatic void queue_req(heap_req_type it);
      pending = {pending, it};
   endfunction

   // Update the predicted heap with one accepted item; queue a result for drains.
   task automatic heap_apply(input heap_req_type it);
      int unsigned w, pos, up, l, r, big;
      drain_item_type res;
      w = (heap_size_reg == 0) ? 1 : heap_size_reg;
      if (w > HEAP_DEPTH) w = HEAP_DEPTH;
      case (it.kind)
         KIND_OFFER: begin
            if (it.vreq) begin
               if (kept < w) begin
                  heap_dist[kept] = it.distance;
                  heap_idx[kept] = it.idx;
                  pos = kept;
                  while (pos > 0) begin
                     up = (pos - 1) / 2;
                     if (heap_dist[up] >= heap_dist[pos]) break;
                     swap_entries(up, pos);
                     pos = up;
                  end
                  kept++;
                  if (kept > peak_kept) peak_kept = kept;
               end else if (kept > 0 && it.distance < heap_dist[0]) begin
                  // full heap: replace the root and sift it down along one path
                  heap_dist[0] = it.distance;
                  heap_idx[0] = it.idx;
                  pos = 0;
                  forever begin
                     l = 2 * pos + 1;
                     r = 2 * pos + 2;
                     big = pos;
                     if (l < kept && heap_dist[l] > heap_dist[big]) big = l;
                     if (r < kept && heap_dist[r] > heap_dist[big]) big = r;
                     if (big == pos) break;
                     swap_entries(pos, big);
                     pos = big;
                  end
               end
            end
         end
         KIND_DRAIN: begin
            res = '0;
            if (kept == 0) begin
               res.empty = 1'b1;
            end else begin
               if (drain_at >= kept) drain_at = 0;
               res.distance = heap_dist[drain_at];
               res.idx = heap_idx[drain_at];
               res.last = (drain_at + 1 == kept);
               drain_at = res.last ? 0 : drain_at + 1;
            end
            drain_results_due = {drain_results_due, res};
         end
         KIND_CLEAR: begin
            kept = 0;
            drain_at = 0;
         end
         default: ;
      endcase
   endtask

   function automatic void flag_mismatch(string what, drain_item_type want,
                                         drain_item_type got);
      if (mismatches < 10)
         $display("%s: expected d=%h i=%h last=%b empty=%b, got d=%h i=%h last=%b empty=%b",
                  what, want.distance, want.idx, want.last, want.empty,
                  got.distance, got.idx, got.last, got.empty);
      mismatches++;
   endfunction

   function automatic logic [DIST_W-1:0] rand_dist();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom_range(0, 15);
         4: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return IDX_W'($urandom_range(0, 24'hFF_FFFF));
      endcase
   endfunction

   task automatic push_req(input logic [1:0] k, input logic [DIST_W-1:0] d,
                           input logic [IDX_W-1:0] i, input logic v);
      heap_req_type it;
      it.kind = k;
      it.distance = d;
      it.idx = i;
      it.vreq = v;
      queue_req(it);
   endtask

   // Ignored items (invalid offers, unused kind) are not counted against n.
   task automatic push_random(int n, int drain_pct, int clear_pct, int noise_pct);
      int r, run;
      heap_req_type it;
      while (n > 0) begin
         r = $urandom_range(0, 99);
         it.distance = rand_dist();
         it.idx = rand_index();
         it.vreq = 1'($urandom_range(0, 1));
         if (r < drain_pct) begin
            run = $urandom_range(1, 8);
            it.kind = KIND_DRAIN;
            repeat (run) queue_req(it);
            n -= run;
         end else if (r < drain_pct + clear_pct) begin
            it.kind = KIND_CLEAR;
            queue_req(it);
            n--;
         end else if (r < drain_pct + clear_pct + noise_pct) begin
            if ($urandom_range(0, 1)) begin
               it.kind = KIND_UNUSED;
            end else begin
               it.kind = KIND_OFFER;
               it.vreq = 1'b0;
            end
            queue_req(it);
         end else begin
            it.kind = KIND_OFFER;
            it.vreq = 1'b1;
            queue_req(it);
            n--;
         end
      end
   endtask

   // Hold until the sender is empty and every drain result is in, then let the heap finish.
   task automatic settle();
      do @(negedge clock);
      while (pending.size() != 0 || req_valid || drain_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_heap_size(input logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_heap_size <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      heap_size_reg = v;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic random_phase(input logic [CFG_W-1:0] w, int n, int drain_pct,
                               int clear_pct, int noise_pct);
      settle();
      write_heap_size(w);
      push_random(n, drain_pct, clear_pct, noise_pct);
   endtask

   initial begin
      kept = 0;
      drain_at = 0;
      peak_kept = 0;
      heap_size_reg = DEFAULT_HEAP_SIZE;
      for (int k = 0; k < HEAP_DEPTH; k++) begin
         heap_dist[k] = '0;
         heap_idx[k] = '0;
      end

      // default W: empty drain, extremes, ignored items, drain run with wrap, clear
      push_req(KIND_DRAIN, 32'h1234_5678, 24'h00_00FF, 1'b1);
      push_req(KIND_OFFER, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
      push_req(KIND_OFFER, 32'h0000_0000, 24'h00_0000, 1'b1);
      push_req(KIND_OFFER, 32'h0000_1234, 24'h12_3456, 1'b0);
      push_req(KIND_UNUSED, 32'h0000_0001, 24'h00_0001, 1'b1);
      push_req(KIND_OFFER, 32'h8000_0000, 24'h5A_5A5A, 1'b1);
      push_req(KIND_OFFER, 32'hFFFF_FFFF, 24'h00_0001, 1'b1);
      repeat (5) push_req(KIND_DRAIN, 32'h0, 24'h0, 1'b0);
      push_req(KIND_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
      push_req(KIND_DRAIN, 32'h0, 24'h0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero acts as one: equal distance rejected, smaller replaces, larger rejected
      settle();
      write_heap_size(10'd0);
      push_req(KIND_OFFER, 32'd5, 24'd1, 1'b1);
      push_req(KIND_OFFER, 32'd5, 24'd2, 1'b1);
      push_req(KIND_OFFER, 32'd3, 24'd3, 1'b1);
      push_req(KIND_OFFER, 32'd9, 24'd4, 1'b1);
      repeat (2) push_req(KIND_DRAIN, 32'h0, 24'h0, 1'b0);

      // equal distances: no sift-up past a tie, left child wins in sift-down
      settle();
      write_heap_size(10'd3);
      push_req(KIND_CLEAR, 32'h0, 24'h0, 1'b0);
      push_req(KIND_OFFER, 32'd10, 24'd1, 1'b1);
      push_req(KIND_OFFER, 32'd10, 24'd2, 1'b1);
      push_req(KIND_OFFER, 32'd10, 24'd3, 1'b1);
      push_req(KIND_OFFER, 32'd4, 24'd4, 1'b1);
      repeat (3) push_req(KIND_DRAIN, 32'h0, 24'h0, 1'b0);

      // shrink below the held count, then fill to the saturated maximum
      random_phase(10'd1, 20, 20, 0, 10);
      random_phase(10'd1023, 560, 2, 0, 0);
      random_phase(10'd512, 15, 20, 0, 10);
      random_phase(10'd4, 20, 20, 0, 10);

      // long result hold while drains keep coming, so the input backs up
      settle();
      write_heap_size(10'd5);
      hold_asks++;
      push_req(KIND_CLEAR, 32'h0, 24'h0, 1'b0);
      push_random(40, 60, 0, 5);

      random_phase(10'd2, 20, 15, 5, 10);
      random_phase(10'd9, 20, 15, 5, 10);
      random_phase(10'd300, 20, 15, 5, 10);

      settle();
      $display("Run covered %0d requests and %0d drain items over %0d heap_size settings;",
               requests_taken, drains_checked, settings_used);
      $display("peak fill %0d entries, %0d mismatches", peak_kept, mismatches);
      if (mismatches == 0) begin
         $display("PASS top_w_max_heap_select");
      end else begin
         $display("FAIL top_w_max_heap_select");
      end
      $finish;
   end

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            heap_apply(drive_item);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               drive_item = pending.pop_front();
               req_valid <= 1'b1;
               req_kind <= drive_item.kind;
               req_distance <= drive_item.distance;
               req_cand_index <= drive_item.idx;
               req_valid_req <= drive_item.vreq;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall pattern, with one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      drain_item_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.distance = rsp_out_distance;
         got.idx = rsp_out_index;
         got.last = rsp_last;
         got.empty = rsp_empty_res;
         if (drain_results_due.size() == 0) begin
            flag_mismatch("unexpected drain item", '0, got);
         end else begin
            want = drain_results_due.pop_front();
            if (got.distance !== want.distance || got.idx !== want.idx ||
                got.last !== want.last || got.empty !== want.empty)
               flag_mismatch("drain item mismatch", want, got);
         end
         drains_checked++;
      end
   end

   // watchdog: end the run after too many cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a handshake", idle_cycles);
         $display("FAIL top_w_max_heap_select");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
